FILE: sv/tbi_pkg.sv
package tbi_pkg;

  // per-beat status carried alongside the divider datapath
  typedef struct packed {
    logic hit;
    logic degen;
    logic neg;
    logic ovf;
  } tbi_flags_t;

endpackage

FILE: sv/tbi_front.sv
module tbi_front #(
  parameter int CW = 16,
  parameter int VW = 24,
  parameter int PW = 2 * (CW + 1) + 1,
  parameter int MW = PW + 2 + VW + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [CW-1:0]   ax,
  input  logic signed [CW-1:0]   ay,
  input  logic signed [VW-1:0]   z0,
  input  logic signed [CW-1:0]   bx,
  input  logic signed [CW-1:0]   by,
  input  logic signed [VW-1:0]   z1,
  input  logic signed [CW-1:0]   cx,
  input  logic signed [CW-1:0]   cy,
  input  logic signed [VW-1:0]   z2,
  input  logic signed [CW-1:0]   px,
  input  logic signed [CW-1:0]   py,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic [MW-1:0]          dn_rem,
  output logic [PW-1:0]          dn_d,
  output tbi_pkg::tbi_flags_t    dn_flags
);
  import tbi_pkg::*;

  localparam int DW  = CW + 1;
  localparam int N0W = PW + 2;

  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r;
  logic ra, rb, rc, rd, re, rf;

  assign rf = !vf_r || dn_ready;
  assign re = !ve_r || rf;
  assign rd = !vd_r || re;
  assign rc = !vc_r || rd;
  assign rb = !vb_r || rc;
  assign ra = !va_r || rb;
  assign in_ready = ra;

  // stage a: edge vectors from vertex 0
  logic signed [DW-1:0] e2x_r, e2y_r, e1x_r, e1y_r, qx_r, qy_r;
  logic signed [VW-1:0] za0_r, za1_r, za2_r;
  // stage b: cross products
  logic signed [2*DW-1:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic signed [VW-1:0] zb0_r, zb1_r, zb2_r;
  // stage c: numerators
  logic signed [PW-1:0]  detc_r, n1_r, n2_r;
  logic signed [N0W-1:0] n0_r;
  logic signed [VW-1:0]  zc0_r, zc1_r, zc2_r;
  logic                  insc_r, degc_r;
  logic signed [PW-1:0]  det_nxt, n1_nxt, n2_nxt;
  logic signed [PW:0]    nsum;
  logic                  ins_nxt;
  // stage d: weighted values
  logic signed [N0W+VW-1:0] m0_r;
  logic signed [PW+VW-1:0]  m1_r, m2_r;
  logic signed [PW-1:0]     detd_r;
  logic                     insd_r, degd_r;
  // stage e: magnitudes
  logic signed [MW-1:0] num;
  logic [MW-1:0]        mage_r;
  logic [PW-1:0]        dmage_r;
  logic                 inse_r, dege_r, nege_r;
  // stage f: quotient range check
  logic [MW-1:0]        magf_r;
  logic [PW-1:0]        dmagf_r;
  tbi_flags_t           flf_r;
  logic [MW-1:0]        dsh;

  assign det_nxt = $signed({pa_r[2*DW-1], pa_r}) - $signed({pb_r[2*DW-1], pb_r});
  assign n1_nxt  = $signed({pc_r[2*DW-1], pc_r}) - $signed({pd_r[2*DW-1], pd_r});
  assign n2_nxt  = $signed({pe_r[2*DW-1], pe_r}) - $signed({pf_r[2*DW-1], pf_r});
  assign nsum    = $signed({n1_nxt[PW-1], n1_nxt}) + $signed({n2_nxt[PW-1], n2_nxt});

  always_comb begin
    if (det_nxt[PW-1]) begin
      ins_nxt = (n1_nxt <= 0) && (n2_nxt <= 0) && (nsum >= $signed({det_nxt[PW-1], det_nxt}));
    end else begin
      ins_nxt = (n1_nxt >= 0) && (n2_nxt >= 0) && (nsum <= $signed({det_nxt[PW-1], det_nxt}));
    end
  end

  assign num = MW'(m0_r) + MW'(m1_r) + MW'(m2_r);
  assign dsh = {{(MW-PW){1'b0}}, dmage_r} << VW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; vc_r <= 1'b0;
      vd_r <= 1'b0; ve_r <= 1'b0; vf_r <= 1'b0;
    end else begin
      if (ra) va_r <= in_valid;
      if (rb) vb_r <= va_r;
      if (rc) vc_r <= vb_r;
      if (rd) vd_r <= vc_r;
      if (re) ve_r <= vd_r;
      if (rf) vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ra) begin
      e2x_r <= $signed({cx[CW-1], cx}) - $signed({ax[CW-1], ax});
      e2y_r <= $signed({cy[CW-1], cy}) - $signed({ay[CW-1], ay});
      e1x_r <= $signed({bx[CW-1], bx}) - $signed({ax[CW-1], ax});
      e1y_r <= $signed({by[CW-1], by}) - $signed({ay[CW-1], ay});
      qx_r  <= $signed({px[CW-1], px}) - $signed({ax[CW-1], ax});
      qy_r  <= $signed({py[CW-1], py}) - $signed({ay[CW-1], ay});
      za0_r <= z0; za1_r <= z1; za2_r <= z2;
    end
    if (rb) begin
      pa_r <= e2x_r * e1y_r;
      pb_r <= e2y_r * e1x_r;
      pc_r <= e2x_r * qy_r;
      pd_r <= e2y_r * qx_r;
      pe_r <= qx_r * e1y_r;
      pf_r <= qy_r * e1x_r;
      zb0_r <= za0_r; zb1_r <= za1_r; zb2_r <= za2_r;
    end
    if (rc) begin
      detc_r <= det_nxt;
      n1_r   <= n1_nxt;
      n2_r   <= n2_nxt;
      n0_r   <= N0W'(det_nxt) - N0W'(n1_nxt) - N0W'(n2_nxt);
      insc_r <= ins_nxt;
      degc_r <= (det_nxt == '0);
      zc0_r <= zb0_r; zc1_r <= zb1_r; zc2_r <= zb2_r;
    end
    if (rd) begin
      m0_r   <= n0_r * zc0_r;
      m1_r   <= n1_r * zc1_r;
      m2_r   <= n2_r * zc2_r;
      detd_r <= detc_r;
      insd_r <= insc_r && !degc_r;
      degd_r <= degc_r;
    end
    if (re) begin
      mage_r  <= num[MW-1] ? MW'(-num) : MW'(num);
      dmage_r <= detd_r[PW-1] ? PW'(-detd_r) : PW'(detd_r);
      nege_r  <= num[MW-1] ^ detd_r[PW-1];
      inse_r  <= insd_r;
      dege_r  <= degd_r;
    end
    if (rf) begin
      magf_r     <= mage_r;
      dmagf_r    <= dmage_r;
      flf_r.hit    <= inse_r;
      flf_r.degen  <= dege_r;
      flf_r.neg    <= nege_r;
      flf_r.ovf    <= (mage_r >= dsh);
    end
  end

  assign dn_valid = vf_r;
  assign dn_rem   = magf_r;
  assign dn_d     = dmagf_r;
  assign dn_flags = flf_r;

endmodule

FILE: sv/tbi_div_cell.sv
module tbi_div_cell #(
  parameter int K  = 0,
  parameter int VW = 24,
  parameter int PW = 35,
  parameter int MW = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [MW-1:0]       up_rem,
  input  logic [PW-1:0]       up_d,
  input  logic [VW-1:0]       up_q,
  input  tbi_pkg::tbi_flags_t up_flags,
  output logic                dn_valid,
  input  logic                dn_ready,
  output logic [MW-1:0]       dn_rem,
  output logic [PW-1:0]       dn_d,
  output logic [VW-1:0]       dn_q,
  output tbi_pkg::tbi_flags_t dn_flags
);
  import tbi_pkg::*;

  logic             v_r;
  logic [MW-1:0]    rem_r;
  logic [PW-1:0]    d_r;
  logic [VW-1:0]    q_r;
  tbi_flags_t       fl_r;
  logic [MW-1:0]    dsh;
  logic             ge;
  logic [VW-1:0]    q_nxt;

  // one restoring step: try divisor scaled to this quotient bit
  assign dsh = {{(MW-PW){1'b0}}, up_d} << K;
  assign ge  = (up_rem >= dsh);

  always_comb begin
    q_nxt    = up_q;
    q_nxt[K] = ge;
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      rem_r <= ge ? (up_rem - dsh) : up_rem;
      d_r   <= up_d;
      q_r   <= q_nxt;
      fl_r  <= up_flags;
    end
  end

  assign dn_valid = v_r;
  assign dn_rem   = rem_r;
  assign dn_d     = d_r;
  assign dn_q     = q_r;
  assign dn_flags = fl_r;

endmodule

FILE: sv/triangle_barycentric_interpolator.sv
// throughput: one beat per cycle while the output is not stalled; six front
// stages (edges, crosses, numerators, weighted sums, magnitudes, range check),
// then one divider cell per quotient bit
// each stage holds its beat only while the one after it is full and stalled
// reset (rst_n low, synchronous) empties every stage; no other state
module triangle_barycentric_interpolator #(
  parameter int COORD_WIDTH = 16,
  parameter int VALUE_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_vertex0_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex0_y,
  input  logic signed [VALUE_WIDTH-1:0] in_vertex0_value,
  input  logic signed [COORD_WIDTH-1:0] in_vertex1_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex1_y,
  input  logic signed [VALUE_WIDTH-1:0] in_vertex1_value,
  input  logic signed [COORD_WIDTH-1:0] in_vertex2_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex2_y,
  input  logic signed [VALUE_WIDTH-1:0] in_vertex2_value,
  input  logic signed [COORD_WIDTH-1:0] in_query_x,
  input  logic signed [COORD_WIDTH-1:0] in_query_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_inside_res,
  output logic                          out_degenerate,
  output logic signed [VALUE_WIDTH-1:0] out_interpolated,
  output logic                          out_saturated
);
  import tbi_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int PW = 2 * (COORD_WIDTH + 1) + 1;
  localparam int MW = PW + 2 + VW + 1;
  localparam logic [VW-1:0] LIM = {1'b1, {(VW-1){1'b0}}};

  logic            cv   [VW+1];
  logic            cr   [VW+1];
  logic [MW-1:0]   crem [VW+1];
  logic [PW-1:0]   cd   [VW+1];
  logic [VW-1:0]   cq   [VW+1];
  tbi_flags_t      cfl  [VW+1];

  tbi_front #(.CW(COORD_WIDTH), .VW(VW), .PW(PW), .MW(MW)) u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .ax(in_vertex0_x), .ay(in_vertex0_y), .z0(in_vertex0_value),
    .bx(in_vertex1_x), .by(in_vertex1_y), .z1(in_vertex1_value),
    .cx(in_vertex2_x), .cy(in_vertex2_y), .z2(in_vertex2_value),
    .px(in_query_x), .py(in_query_y),
    .dn_valid(cv[0]), .dn_ready(cr[0]), .dn_rem(crem[0]), .dn_d(cd[0]),
    .dn_flags(cfl[0])
  );
  assign cq[0] = '0;

  for (genvar i = 0; i < VW; i++) begin : g_cell
    tbi_div_cell #(.K(VW-1-i), .VW(VW), .PW(PW), .MW(MW)) u_cell (
      .clk, .rst_n,
      .up_valid(cv[i]), .up_ready(cr[i]), .up_rem(crem[i]), .up_d(cd[i]),
      .up_q(cq[i]), .up_flags(cfl[i]),
      .dn_valid(cv[i+1]), .dn_ready(cr[i+1]), .dn_rem(crem[i+1]), .dn_d(cd[i+1]),
      .dn_q(cq[i+1]), .dn_flags(cfl[i+1])
    );
  end

  logic            out_valid_r, ld;
  logic            ins_r, deg_r, sat_r;
  logic [VW-1:0]   val_r;
  logic            sat_nxt;
  logic [VW-1:0]   val_nxt;
  logic [VW-1:0]   q;
  tbi_flags_t      fl;

  assign q  = cq[VW];
  assign fl = cfl[VW];
  assign cr[VW] = !out_valid_r || out_ready;
  assign ld = cv[VW] && cr[VW];

  always_comb begin
    sat_nxt = 1'b0;
    val_nxt = '0;
    if (fl.degen) begin
      val_nxt = '0;
    end else if (fl.neg) begin
      if (fl.ovf || q > LIM) begin
        sat_nxt = 1'b1;
        val_nxt = LIM;
      end else begin
        val_nxt = VW'(-q);
      end
    end else begin
      if (fl.ovf || q[VW-1]) begin
        sat_nxt = 1'b1;
        val_nxt = ~LIM;
      end else begin
        val_nxt = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cr[VW]) begin
      out_valid_r <= cv[VW];
    end
    if (ld) begin
      ins_r <= fl.hit && !fl.degen;
      deg_r <= fl.degen;
      sat_r <= sat_nxt;
      val_r <= val_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_inside_res   = ins_r;
  assign out_degenerate   = deg_r;
  assign out_saturated    = sat_r;
  assign out_interpolated = $signed(val_r);

  // flat triangle gives no value, no clamp, no hit
  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && deg_r |-> val_r == '0 && !sat_r && !ins_r)
    else $error("degenerate result not cleared");

  // a clamped value sits at one end of the range
  a_sat_end : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sat_r |-> val_r == LIM || val_r == ~LIM)
    else $error("saturated value not at range end");

  // input side only backs up when the result beat is held
  a_backpressure : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r && !out_ready)
    else $error("input stalled with output free");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

// interpolation scoreboard: computes expected results and compares beats in order
class interp_scoreboard;
  typedef struct {
    logic                hit;
    logic                degen;
    logic signed [23:0]  value;
    logic                sat;
  } interp_result_t;

  interp_result_t pending[$];
  int errors;

  function void note_input(logic signed [15:0] ax, logic signed [15:0] ay,
                           logic signed [23:0] z0, logic signed [15:0] bx,
                           logic signed [15:0] by, logic signed [23:0] z1,
                           logic signed [15:0] cx, logic signed [15:0] cy,
                           logic signed [23:0] z2, logic signed [15:0] px,
                           logic signed [15:0] py);
    longint e2x, e2y, e1x, e1y, qx, qy, det, n1, n2, n0;
    logic signed [127:0] num, quo;
    interp_result_t r;
    e2x = longint'(cx) - ax;
    e2y = longint'(cy) - ay;
    e1x = longint'(bx) - ax;
    e1y = longint'(by) - ay;
    qx = longint'(px) - ax;
    qy = longint'(py) - ay;
    det = e2x * e1y - e2y * e1x;
    n1 = e2x * qy - e2y * qx;
    n2 = qx * e1y - qy * e1x;
    n0 = det - n1 - n2;
    r.hit = 0;
    r.degen = (det == 0);
    r.value = 0;
    r.sat = 0;
    if (det != 0) begin
      if (det > 0) r.hit = (n1 >= 0 && n2 >= 0 && n1 + n2 <= det);
      else r.hit = (n1 <= 0 && n2 <= 0 && n1 + n2 >= det);
      num = 128'(signed'(n0)) * z0 + 128'(signed'(n1)) * z1 + 128'(signed'(n2)) * z2;
      // signed division truncates toward zero
      quo = num / 128'(signed'(det));
      if (quo > 128'sd8388607) begin
        r.value = 24'sh7fffff;
        r.sat = 1;
      end else if (quo < -128'sd8388608) begin
        r.value = 24'sh800000;
        r.sat = 1;
      end else begin
        r.value = quo[23:0];
      end
    end
    pending.push_back(r);
  endfunction

  function void check_result(logic hit, logic degen, logic signed [23:0] value,
                             logic sat);
    interp_result_t e;
    if (pending.size() == 0) begin
      $error("result beat with nothing expected");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (hit !== e.hit) begin
      $error("inside_res exp %0d got %0d", e.hit, hit);
      errors++;
    end
    if (degen !== e.degen) begin
      $error("degenerate exp %0d got %0d", e.degen, degen);
      errors++;
    end
    if (value !== e.value) begin
      $error("interpolated exp %0d got %0d", e.value, value);
      errors++;
    end
    if (sat !== e.sat) begin
      $error("saturated exp %0d got %0d", e.sat, sat);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int LATENCY = 24 + 7;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [15:0] v0x, v0y, v1x, v1y, v2x, v2y, qx, qy;
  logic signed [23:0] v0z, v1z, v2z;
  logic out_inside_res, out_degenerate, out_saturated;
  logic signed [23:0] out_interpolated;

  interp_scoreboard board;
  int cycles;
  bit hold_off;

  triangle_barycentric_interpolator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vertex0_x(v0x), .in_vertex0_y(v0y), .in_vertex0_value(v0z),
    .in_vertex1_x(v1x), .in_vertex1_y(v1y), .in_vertex1_value(v1z),
    .in_vertex2_x(v2x), .in_vertex2_y(v2y), .in_vertex2_value(v2z),
    .in_query_x(qx), .in_query_y(qy),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_inside_res(out_inside_res), .out_degenerate(out_degenerate),
    .out_interpolated(out_interpolated), .out_saturated(out_saturated)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] rand_coord(int shape);
    case (shape)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 200)) - 16'sd100;
      default: begin
        case ($urandom_range(0, 2))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [23:0] rand_value(int shape);
    if (shape == 2) begin
      case ($urandom_range(0, 2))
        0: return 24'sh7fffff;
        1: return 24'sh800000;
        default: return 24'($urandom);
      endcase
    end
    return 24'($urandom);
  endfunction

  // present one beat and hold it until accepted
  task automatic send_beat(logic signed [15:0] ax, logic signed [15:0] ay,
                           logic signed [23:0] z0, logic signed [15:0] bx,
                           logic signed [15:0] by, logic signed [23:0] z1,
                           logic signed [15:0] cx, logic signed [15:0] cy,
                           logic signed [23:0] z2, logic signed [15:0] px,
                           logic signed [15:0] py);
    in_valid <= 1;
    v0x <= ax; v0y <= ay; v0z <= z0;
    v1x <= bx; v1y <= by; v1z <= z1;
    v2x <= cx; v2y <= cy; v2z <= z2;
    qx <= px; qy <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(ax, ay, z0, bx, by, z1, cx, cy, z2, px, py);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_random(int shape);
    logic signed [15:0] ax, ay, bx, by, cx, cy, px, py;
    ax = rand_coord(shape); ay = rand_coord(shape);
    bx = rand_coord(shape); by = rand_coord(shape);
    cx = rand_coord(shape); cy = rand_coord(shape);
    px = rand_coord(shape); py = rand_coord(shape);
    // sometimes collapse the triangle onto a line
    if ($urandom_range(0, 15) == 0) begin
      cx = 16'(ax + 2 * (bx - ax));
      cy = 16'(ay + 2 * (by - ay));
    end
    if ($urandom_range(0, 7) == 0) begin
      px = ax; py = ay;
    end
    send_beat(ax, ay, rand_value(shape), bx, by, rand_value(shape), cx, cy,
              rand_value(shape), px, py);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // receiver side: random stalls plus one long hold-off on request
  initial begin
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (150) @(posedge clk);
        hold_off = 0;
      end
      out_ready <= ($urandom_range(0, 99) < 70) || (cycles > 200000);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_inside_res, out_degenerate, out_interpolated, out_saturated);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    board = new();
    hold_off = 0;
    rst_n = 0;
    in_valid = 0;
    {v0x, v0y, v1x, v1y, v2x, v2y, qx, qy} = '0;
    {v0z, v1z, v2z} = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // right triangle with legs of 10, query at two vertices, on the long edge and outside
    send_beat(0, 0, 100, 10, 0, 200, 0, 10, 300, 0, 0);
    send_beat(0, 0, 100, 10, 0, 200, 0, 10, 300, 10, 0);
    send_beat(0, 0, 100, 10, 0, 200, 0, 10, 300, 5, 5);
    send_beat(0, 0, 100, 10, 0, 200, 0, 10, 300, 6, 6);
    send_beat(0, 0, 100, 10, 0, 200, 0, 10, 300, -3, 4);
    // clockwise winding gives positive determinant
    send_beat(0, 0, -100, 0, 10, 200, 10, 0, 300, 2, 3);
    send_beat(0, 0, -7, 0, 3, 5, 3, 0, 1, 1, 1);
    // degenerate: coincident and collinear
    send_beat(5, 5, 9, 5, 5, 9, 5, 5, 9, 5, 5);
    send_beat(0, 0, 1, 1, 1, 2, 2, 2, 3, 7, 1);
    // extreme coords and values, saturating extrapolation
    send_beat(-32768, -32768, 24'sh7fffff, 32767, -32768, 24'sh800000,
              -32768, 32767, 24'sh7fffff, 32767, 32767);
    send_beat(0, 0, 24'sh7fffff, 1, 0, 24'sh800000, 0, 1, 24'sh7fffff,
              -32768, 32767);
    send_beat(0, 0, 24'sh800000, 1, 0, 24'sh7fffff, 0, 1, 24'sh800000,
              32767, -32768);
    send_beat(32767, 32767, -1, -32768, 32767, 0, 32767, -32768, 1,
              -32768, -32768);
    send_beat(-1, -1, 24'sh7fffff, -1, 0, 24'sh7fffff, 0, -1, 24'sh7fffff, 0, 0);
    send_beat(3, 0, 1, 0, 0, -1, 0, 3, 0, 1, 1);

    // let the sender pause until every result is back
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    hold_off = 1;
    for (int i = 0; i < 60; i++) send_random($urandom_range(0, 2));

    for (int i = 0; i < 800; i++) begin
      if ($urandom_range(0, 3) != 0) idle_cycles(gap_len());
      send_random($urandom_range(0, 2));
      if (i == 400) wait_drained();
    end
    in_valid <= 0;

    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end
endmodule
